// ----- src/swr_pkg.sv -----
`timescale 1ns / 1ps
// swr_pkg: codes, reset values and shared types of the sample receiver.
// No dependencies; used by every module of the block.
package swr_pkg;

  localparam int MAX_WORDS = 8;
  localparam int WORD_W    = 16;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_PACKET = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [7:0] MSG_HEART  = 8'd1;
  localparam logic [7:0] MSG_SAMPLE = 8'd2;
  localparam logic [7:0] MSG_FINAL  = 8'd7;
  localparam logic [7:0] ACK_TYPE   = 8'h03;

  localparam logic [1:0] CFG_NET_ID      = 2'd0;
  localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [15:0] NET_ID_RST      = 16'hCABA;
  localparam logic [15:0] RETRY_LIMIT_RST = 16'd4;
  localparam logic [15:0] TIMEOUT_RST     = 16'd4500;
  localparam logic [15:0] CNT_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [15:0] net_id;
    logic [15:0] retry_limit;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic                               active;
    logic                               final_seen;
    logic [7:0]                         expected_seq;
    logic [15:0]                        retry_count;
    logic [15:0]                        rate_value;
    logic [MAX_WORDS-1:0][WORD_W-1:0]   samples;
    logic [15:0]                        idle_ticks;
  } state_t;

  typedef struct packed {
    logic        ack_valid;
    logic [15:0] ack_net_id;
    logic [15:0] ack_word;
    logic        updated;
    logic        receiving;
    logic        closed;
    logic [15:0] heart_rate;
    logic [63:0] samples_low;
    logic [63:0] samples_high;
  } result_t;

endpackage

// ----- src/swr_step.sv -----
`timescale 1ns / 1ps
// swr_step: next-state and result logic for one beat of the receiver.
// Depends on swr_pkg.
module swr_step #(
  parameter int SAMPLE_WORDS = 8
) (
  input  swr_pkg::state_t  st,
  input  swr_pkg::cfg_t    cfg,
  input  logic [1:0]       mode,
  input  logic [7:0]       msg_type,
  input  logic [7:0]       seq_num,
  input  logic [63:0]      payload_low,
  input  logic [63:0]      payload_high,
  output swr_pkg::state_t  st_nxt,
  output swr_pkg::result_t res
);

  logic        ack;
  logic        upd;
  logic        cls;
  logic        nack_req;
  logic        is_sample;
  logic [15:0] idle_inc;
  logic [7:0]  ack_seq;

  assign is_sample = (msg_type == swr_pkg::MSG_SAMPLE) || (msg_type == swr_pkg::MSG_FINAL);
  assign idle_inc  = (st.idle_ticks == swr_pkg::CNT_MAX) ? st.idle_ticks
                                                         : st.idle_ticks + 16'd1;

  always_comb begin
    st_nxt   = st;
    ack      = 1'b0;
    upd      = 1'b0;
    cls      = 1'b0;
    nack_req = 1'b0;
    unique case (mode)
      swr_pkg::MODE_START: begin
        upd                 = !st.active;
        st_nxt.final_seen   = 1'b0;
        st_nxt.expected_seq = 8'd0;
        st_nxt.retry_count  = 16'd0;
        st_nxt.idle_ticks   = 16'd0;
        st_nxt.active       = 1'b1;
      end
      swr_pkg::MODE_PACKET: begin
        st_nxt.idle_ticks = 16'd0;
        if (msg_type == swr_pkg::MSG_HEART) begin
          st_nxt.rate_value = payload_low[15:0];
          upd               = 1'b1;
        end else if (is_sample && st.active) begin
          if (seq_num == st.expected_seq) begin
            if ((msg_type == swr_pkg::MSG_FINAL) && st.final_seen) begin
              st_nxt.active = 1'b0;
              upd           = 1'b1;
              cls           = 1'b1;
            end else begin
              if (msg_type == swr_pkg::MSG_FINAL) begin
                st_nxt.final_seen = 1'b1;
              end
              for (int i = 0; i < swr_pkg::MAX_WORDS; i++) begin
                if (i < SAMPLE_WORDS) begin
                  st_nxt.samples[i] = (i < 4) ? payload_low[16*(i%4) +: 16]
                                              : payload_high[16*(i%4) +: 16];
                end
              end
              upd                 = 1'b1;
              st_nxt.expected_seq = st.expected_seq + 8'd1;
              st_nxt.retry_count  = 16'd0;
              ack                 = 1'b1;
            end
          end else begin
            nack_req = 1'b1;
          end
        end
      end
      swr_pkg::MODE_TICK: begin
        if (st.active) begin
          if (idle_inc >= cfg.timeout_ticks) begin
            st_nxt.idle_ticks = 16'd0;
            nack_req          = 1'b1;
          end else begin
            st_nxt.idle_ticks = idle_inc;
          end
        end else begin
          st_nxt.idle_ticks = 16'd0;
        end
      end
      default: begin
      end
    endcase

    if (nack_req) begin
      if (st.final_seen && (st.retry_count >= cfg.retry_limit)) begin
        st_nxt.active = 1'b0;
        upd           = 1'b1;
        cls           = 1'b1;
      end else begin
        if (st.retry_count != swr_pkg::CNT_MAX) begin
          st_nxt.retry_count = st.retry_count + 16'd1;
        end
        ack = 1'b1;
      end
    end
  end

  assign ack_seq = st_nxt.expected_seq - 8'd1;

  always_comb begin
    res.ack_valid    = ack;
    res.ack_net_id   = ack ? cfg.net_id : 16'd0;
    res.ack_word     = ack ? {swr_pkg::ACK_TYPE, ack_seq} : 16'd0;
    res.updated      = upd;
    res.receiving    = st_nxt.active;
    res.closed       = cls;
    res.heart_rate   = st_nxt.rate_value;
    res.samples_low  = st_nxt.samples[3:0];
    res.samples_high = st_nxt.samples[7:4];
  end

endmodule

// ----- src/stop_and_wait_sample_receiver.sv -----
`timescale 1ns / 1ps
// stop_and_wait_sample_receiver: receiving side of a stop-and-wait sample link.
// Depends on swr_pkg and swr_step.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in_     | in_valid / in_stall  | mode, msg_type, seq_num, payload_low/high
//  out_    | out_valid / out_stall| ack frame, flags, heart_rate, samples
//  cfg_    | cfg_valid / cfg_ready| cfg_index (0..2), cfg_data
//
// One beat per cycle while in_stall is low; each result is registered in out_r or the skid entry.
// Link state updates at the accepting edge, so back-to-back beats chain.
// Output register plus one skid entry; in_stall rises only when both are full.
// rst_n (sync) clears link state, samples and config to their defaults.
module stop_and_wait_sample_receiver #(
  parameter int SAMPLE_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_msg_type,
  input  logic [7:0]  in_seq_num,
  input  logic [63:0] in_payload_low,
  input  logic [63:0] in_payload_high,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ack_valid,
  output logic [15:0] out_ack_net_id,
  output logic [15:0] out_ack_word,
  output logic        out_updated,
  output logic        out_receiving,
  output logic        out_closed,
  output logic [15:0] out_heart_rate,
  output logic [63:0] out_samples_low,
  output logic [63:0] out_samples_high,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  swr_pkg::cfg_t    cfg_r;
  swr_pkg::state_t  st_r;
  swr_pkg::state_t  st_nxt;
  swr_pkg::result_t res_nxt;
  swr_pkg::result_t out_r;
  swr_pkg::result_t skid_r;
  logic             out_vld_r;
  logic             skid_vld_r;
  logic             accept;
  logic             take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign accept    = in_valid && !in_stall;
  assign take      = out_vld_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.net_id        <= swr_pkg::NET_ID_RST;
      cfg_r.retry_limit   <= swr_pkg::RETRY_LIMIT_RST;
      cfg_r.timeout_ticks <= swr_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        swr_pkg::CFG_NET_ID:      cfg_r.net_id        <= cfg_data;
        swr_pkg::CFG_RETRY_LIMIT: cfg_r.retry_limit   <= cfg_data;
        swr_pkg::CFG_TIMEOUT:     cfg_r.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  swr_step #(
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_step (
    .st           (st_r),
    .cfg          (cfg_r),
    .mode         (in_mode),
    .msg_type     (in_msg_type),
    .seq_num      (in_seq_num),
    .payload_low  (in_payload_low),
    .payload_high (in_payload_high),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (take) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_vld_r || take) begin
        out_r     <= res_nxt;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res_nxt;
        skid_vld_r <= 1'b1;
      end
    end else if (take) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_ack_valid    = out_r.ack_valid;
  assign out_ack_net_id   = out_r.ack_net_id;
  assign out_ack_word     = out_r.ack_word;
  assign out_updated      = out_r.updated;
  assign out_receiving    = out_r.receiving;
  assign out_closed       = out_r.closed;
  assign out_heart_rate   = out_r.heart_rate;
  assign out_samples_low  = out_r.samples_low;
  assign out_samples_high = out_r.samples_high;

endmodule

// ----- src/swr_checker.sv -----
`timescale 1ns / 1ps
// swr_checker: port-level assertions for the sample receiver, bound to the top.
// Depends on swr_pkg.
module swr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_ack_valid,
  input logic [15:0] out_ack_net_id,
  input logic [15:0] out_ack_word,
  input logic        out_updated,
  input logic        out_receiving,
  input logic        out_closed
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("buffers not empty after reset");

  a_no_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ack_valid |-> out_ack_net_id == 16'd0 && out_ack_word == 16'd0)
    else $error("ack fields nonzero without ack");

  a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_valid |-> out_ack_word[15:8] == swr_pkg::ACK_TYPE
                                   && out_receiving && !out_closed)
    else $error("ack frame malformed or sent outside a transfer");

  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_closed |-> !out_receiving && out_updated)
    else $error("close without state change");

endmodule

bind stop_and_wait_sample_receiver swr_checker u_swr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_ack_valid  (out_ack_valid),
  .out_ack_net_id (out_ack_net_id),
  .out_ack_word   (out_ack_word),
  .out_updated    (out_updated),
  .out_receiving  (out_receiving),
  .out_closed     (out_closed)
);
